### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DEPTH_DEF = 128;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_REPRI  = 2'd2,
        K_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_EXTRACT,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] stamp;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cmd_t;

    typedef struct packed {
        entry_t      head;
        logic        found;
        logic [31:0] found_stamp;
    } chain_st_t;

endpackage

### design/spq_cell.sv
// One storage cell of the sorted queue, exchanging entries with its neighbours.
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  entry_t      left_entry,
    input  logic        left_valid,
    input  logic        left_ge,
    input  entry_t      right_entry,
    input  logic        right_valid,
    input  logic        found_in,
    output entry_t      entry,
    output logic        valid,
    output logic        ge,
    output logic        found_out,
    output logic [31:0] hit_stamp
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   match;

    assign match     = valid_reg && (entry_reg.id == cmd.ent.id);
    assign ge        = valid_reg && (entry_reg.prio >= cmd.ent.prio);
    assign found_out = found_in || match;
    assign hit_stamp = (match && !found_in) ? entry_reg.stamp : 32'd0;
    assign entry     = entry_reg;
    assign valid     = valid_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        entry_next = cmd.ent;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                end
            end
            OP_REMOVE:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            OP_EXTRACT:
            begin
                if (found_out)
                begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### design/spq_ctrl.sv
// Operation sequencer, occupancy counter and result register of the queue.
`timescale 1ns / 1ps
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,
    output cmd_t        cmd,
    input  chain_st_t   chain
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t         state_reg;
    state_t         state_next;
    kind_t          kind_reg;
    logic [15:0]    id_reg;
    logic [31:0]    stamp_reg;
    logic [31:0]    stamp_next;
    logic [7:0]     prio_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    status_t        m_status_reg;
    status_t        m_status_next;
    logic [63:0]    m_data_reg;
    logic [63:0]    m_data_next;
    logic           res_load;
    entry_t         res_ent;
    logic           out_free;
    logic           accept;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (kind_reg == K_REPRI && chain.found)
                    begin
                        state_next = S_REINS;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REINS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NOP;
        cmd.ent.id    = id_reg;
        cmd.ent.stamp = stamp_reg;
        cmd.ent.prio  = prio_reg;
        s_tready      = 1'b0;
        count_next    = count_reg;
        stamp_next    = stamp_reg;
        res_load      = 1'b0;
        res_ent       = '0;
        m_status_next = ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    case (kind_reg)
                        K_INSERT:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                m_status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = OP_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        K_REMOVE:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                m_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = OP_REMOVE;
                                res_ent    = chain.head;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        K_REPRI:
                        begin
                            if (chain.found)
                            begin
                                cmd.op     = OP_EXTRACT;
                                count_next = count_reg - CW'(1);
                                stamp_next = chain.found_stamp;
                            end
                            else
                            begin
                                res_load      = 1'b1;
                                m_status_next = ST_NOT_FOUND;
                            end
                        end
                        K_CLEAR:
                        begin
                            res_load   = 1'b1;
                            cmd.op     = OP_CLEAR;
                            count_next = '0;
                        end
                        default:
                        begin
                            res_load = 1'b0;
                        end
                    endcase
                end
            end
            S_REINS:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        m_valid_next = res_load || (m_valid_reg && !m_tready);
        m_data_next  = {8'(count_next), res_ent.prio, res_ent.stamp, res_ent.id};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            id_reg    <= s_tdata[15:0];
            stamp_reg <= s_tdata[47:16];
            prio_reg  <= s_tdata[55:48];
        end
        else
        begin
            stamp_reg <= stamp_next;
        end
        if (res_load)
        begin
            m_status_reg <= m_status_next;
            m_data_reg   <= m_data_next;
        end
    end

endmodule

### design/sorted_priority_queue_with_reprioritize_top.sv
// Top level of the sorted priority queue: sequencer plus a row of entry cells.
// A result is registered as the sequencer completes its execute state, or, for a
// reprioritize that finds its id, its re-insert state, since it first extracts and then
// re-inserts the entry. A new transaction is accepted only in the idle state, after the
// last one has passed through the cell row; output stalls hold the sequencer.
// Reset clears the occupancy and every cell's valid flag; entry contents are undefined.
`timescale 1ns / 1ps
module sorted_priority_queue_with_reprioritize_top
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // device_id, stamp, priority_req
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_device_id, out_stamp, out_priority, occupancy
    output logic [1:0]  m_tuser    // status
);

    cmd_t        cmd;
    chain_st_t   chain;
    entry_t      entry_w [DEPTH];
    logic        valid_w [DEPTH];
    logic        ge_w    [DEPTH];
    logic        found_w [DEPTH];
    logic [31:0] hit_w   [DEPTH];
    logic [31:0] hit_or;

    spq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .chain    (chain)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t le;
        logic   lv;
        logic   lg;
        logic   fi;
        entry_t re;
        logic   rv;

        if (i == 0)
        begin : g_first
            assign le = '0;
            assign lv = 1'b0;
            assign lg = 1'b1;
            assign fi = 1'b0;
        end
        else
        begin : g_mid
            assign le = entry_w[i-1];
            assign lv = valid_w[i-1];
            assign lg = ge_w[i-1];
            assign fi = found_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign re = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_inner
            assign re = entry_w[i+1];
            assign rv = valid_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (le),
            .left_valid  (lv),
            .left_ge     (lg),
            .right_entry (re),
            .right_valid (rv),
            .found_in    (fi),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .ge          (ge_w[i]),
            .found_out   (found_w[i]),
            .hit_stamp   (hit_w[i])
        );
    end

    always_comb
    begin
        hit_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            hit_or = hit_or | hit_w[k];
        end
    end

    assign chain.head        = entry_w[0];
    assign chain.found       = found_w[DEPTH-1];
    assign chain.found_stamp = hit_or;

endmodule
